### rtl/ssw_pkg.sv
// ----------------------------------------------------------------------------
// ssw_pkg
// shared types, codes and defaults of the stepwise swap sorter
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int ENTRIES_DEF    = 256;
  localparam int VALUE_BITS_DEF = 16;

  // item actions
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // algorithm register codes
  localparam logic [1:0] ALG_BUBBLE    = 2'd0;
  localparam logic [1:0] ALG_SELECTION = 2'd1;
  localparam logic [1:0] ALG_FIRST_INV = 2'd2;
  localparam logic [1:0] ALG_COCKTAIL  = 2'd3;

  typedef enum logic [1:0] {
    WSRC_LOAD = 2'd0,
    WSRC_VB   = 2'd1,
    WSRC_VA   = 2'd2
  } wsrc_t;

  typedef struct packed {
    logic       cap_in;
    logic       rd;
    logic       latch_both;
    logic       latch_min;
    logic       we;
    wsrc_t      wsrc;
    logic       res_load;
    logic       res_swapped;
    logic       res_done;
    logic [7:0] res_first;
    logic [7:0] res_second;
    logic       res_rdv;
  } cmd_t;

  typedef struct packed {
    logic inv;
    logic min_gt;
    logic sel_swap;
  } stat_t;

endpackage

### rtl/ssw_datapath.sv
// ----------------------------------------------------------------------------
// ssw_datapath
// value memory, operand registers, comparators and result registers
// ----------------------------------------------------------------------------
module ssw_datapath import ssw_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW        = $clog2(ENTRIES)
) (
  input  logic            clk,
  input  cmd_t            cmd,
  input  logic [AW-1:0]   ra,
  input  logic [AW-1:0]   rb,
  input  logic [AW-1:0]   waddr,
  input  logic [15:0]     value,
  output stat_t           stat,
  output logic            swapped,
  output logic            done_res,
  output logic [7:0]      first_index,
  output logic [7:0]      second_index,
  output logic [15:0]     read_value
);

  logic [VALUE_BITS-1:0] mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;
  logic [VALUE_BITS-1:0] va;
  logic [VALUE_BITS-1:0] vb;
  logic [VALUE_BITS-1:0] wdata;
  logic [31:0]           in_wide;
  logic [31:0]           rd_wide;

  assign in_wide = 32'(value);
  assign rd_wide = 32'(rd_a);

  always_comb begin
    unique case (cmd.wsrc)
      WSRC_VB: wdata = vb;
      WSRC_VA: wdata = va;
      default: wdata = val_in;
    endcase
  end

  assign stat.inv      = rd_a > rd_b;
  assign stat.min_gt   = vb > rd_b;
  assign stat.sel_swap = vb < va;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      val_in <= in_wide[VALUE_BITS-1:0];
    end
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
    if (cmd.latch_both) begin
      va <= rd_a;
      vb <= rd_b;
    end else if (cmd.latch_min && (vb > rd_b)) begin
      vb <= rd_b;
    end
    if (cmd.res_load) begin
      swapped      <= cmd.res_swapped;
      done_res     <= cmd.res_done;
      first_index  <= cmd.res_first;
      second_index <= cmd.res_second;
      read_value   <= cmd.res_rdv ? rd_wide[15:0] : 16'd0;
    end
  end

endmodule

### rtl/ssw_controller.sv
// ----------------------------------------------------------------------------
// ssw_controller
// sequencer for load, read and the four single-swap sort steps
// ----------------------------------------------------------------------------
module ssw_controller import ssw_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int AW     = $clog2(ENTRIES),
  localparam int PW     = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  logic [7:0]    index,
  output logic          out_valid,
  input  logic          out_ready,
  input  stat_t         stat,
  output cmd_t          cmd,
  output logic [AW-1:0] ra,
  output logic [AW-1:0] rb,
  output logic [AW-1:0] waddr
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'b0000000000000001,
    S_LOAD     = 16'b0000000000000010,
    S_RD       = 16'b0000000000000100,
    S_CHK_RD   = 16'b0000000000001000,
    S_CHK_EV   = 16'b0000000000010000,
    S_SCAN_RD  = 16'b0000000000100000,
    S_SCAN_EV  = 16'b0000000001000000,
    S_CK       = 16'b0000000010000000,
    S_SEL_RD   = 16'b0000000100000000,
    S_SEL_EV   = 16'b0000001000000000,
    S_SEL_KRD  = 16'b0000010000000000,
    S_SEL_KEV  = 16'b0000100000000000,
    S_SEL_DEC  = 16'b0001000000000000,
    S_SWAP_X   = 16'b0010000000000000,
    S_SWAP_Y   = 16'b0100000000000000,
    S_RESULT   = 16'b1000000000000000
  } state_t;

  localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);
  localparam logic [AW-1:0] PEN_A  = AW'(ENTRIES - 2);
  localparam logic [AW:0]   ENT_K  = (AW + 1)'(ENTRIES);
  localparam logic [PW-1:0] ENT_P  = PW'(ENTRIES);

  state_t        state;
  logic [1:0]    alg;
  logic [7:0]    idx;
  logic          idx_ok;
  logic [AW-1:0] idx_a;
  logic [AW+7:0] idx_wide;
  logic [AW-1:0] j;
  logic [AW-1:0] p;
  logic [AW-1:0] m;
  logic [AW:0]   k;
  logic [AW-1:0] sx;
  logic [AW-1:0] sy;
  logic          ck_back;
  logic          ck_dir;
  logic [AW-1:0] scan_pos;
  logic [AW-1:0] outer_pos;
  logic          back_dir;
  logic [PW-1:0] pass_cnt;
  logic [PW-1:0] pc_inc;
  logic [PW-1:0] pc_diff;
  logic [AW-1:0] pass_j;
  logic          rs_swap;
  logic          rs_done;
  logic          rs_rdv;
  logic [7:0]    rs_lo;
  logic [7:0]    rs_hi;
  logic [AW+7:0] sx_wide;
  logic [AW+7:0] sy_wide;
  logic          out_free;
  logic [AW:0]   k_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign idx_ok    = 32'(idx) < 32'(ENTRIES);
  assign idx_wide  = (AW + 8)'(idx);
  assign idx_a     = idx_wide[AW-1:0];
  assign sx_wide   = (AW + 8)'(sx);
  assign sy_wide   = (AW + 8)'(sy);
  assign k_inc     = k + 1'b1;

  // cocktail pass end: saturating pass count and backward start point
  assign pc_inc  = (pass_cnt < ENT_P) ? pass_cnt + 1'b1 : pass_cnt;
  assign pc_diff = ENT_P - pc_inc;
  assign pass_j  = (pc_inc >= ENT_P) ? '0 : pc_diff[AW-1:0];

  always_comb begin
    cmd             = '0;
    cmd.wsrc        = WSRC_LOAD;
    cmd.cap_in      = in_valid && in_ready;
    cmd.res_swapped = rs_swap;
    cmd.res_done    = rs_done;
    cmd.res_first   = rs_lo;
    cmd.res_second  = rs_hi;
    cmd.res_rdv     = rs_rdv;
    ra              = j;
    rb              = j + 1'b1;
    waddr           = idx_a;
    unique case (state)
      S_LOAD: begin
        cmd.we = idx_ok;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        ra     = idx_a;
      end
      S_CHK_RD, S_SCAN_RD: begin
        cmd.rd = 1'b1;
      end
      S_CHK_EV, S_SCAN_EV, S_SEL_EV: begin
        cmd.latch_both = 1'b1;
      end
      S_SEL_RD: begin
        cmd.rd = 1'b1;
        ra     = p;
        rb     = p + 1'b1;
      end
      S_SEL_KRD: begin
        cmd.rd = 1'b1;
        ra     = p;
        rb     = k[AW-1:0];
      end
      S_SEL_KEV: begin
        cmd.latch_min = 1'b1;
      end
      S_SWAP_X: begin
        cmd.we   = 1'b1;
        cmd.wsrc = WSRC_VB;
        waddr    = sx;
      end
      S_SWAP_Y: begin
        cmd.we   = 1'b1;
        cmd.wsrc = WSRC_VA;
        waddr    = sy;
      end
      S_RESULT: begin
        cmd.res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      alg       <= ALG_BUBBLE;
      scan_pos  <= '0;
      outer_pos <= '0;
      back_dir  <= 1'b0;
      pass_cnt  <= PW'(1);
    end else begin
      if (cfg_valid) begin
        alg <= cfg_data;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx     <= index;
            rs_swap <= 1'b0;
            rs_done <= 1'b0;
            rs_rdv  <= 1'b0;
            rs_lo   <= '0;
            rs_hi   <= '0;
            j       <= '0;
            priority case (action)
              ACT_LOAD: state <= S_LOAD;
              ACT_READ: state <= S_RD;
              ACT_STEP: state <= S_CHK_RD;
              default:  state <= S_RESULT;
            endcase
          end
        end
        S_LOAD: begin
          scan_pos  <= '0;
          outer_pos <= '0;
          back_dir  <= 1'b0;
          pass_cnt  <= PW'(1);
          state     <= S_RESULT;
        end
        S_RD: begin
          rs_rdv <= idx_ok;
          state  <= S_RESULT;
        end
        S_CHK_RD: begin
          state <= S_CHK_EV;
        end
        S_CHK_EV: begin
          if (stat.inv) begin
            priority case (alg)
              ALG_FIRST_INV: begin
                sx        <= j;
                sy        <= j + 1'b1;
                scan_pos  <= '0;
                outer_pos <= '0;
                state     <= S_SWAP_X;
              end
              ALG_BUBBLE: begin
                j     <= (scan_pos >= LAST_A) ? '0 : scan_pos;
                state <= S_SCAN_RD;
              end
              ALG_SELECTION: begin
                p     <= (outer_pos >= LAST_A) ? '0 : outer_pos;
                state <= S_SEL_RD;
              end
              default: begin
                j       <= scan_pos;
                ck_back <= back_dir;
                ck_dir  <= back_dir;
                state   <= S_CK;
              end
            endcase
          end else if (j == PEN_A) begin
            rs_done <= 1'b1;
            if (alg == ALG_SELECTION) begin
              outer_pos <= '0;
            end else if (alg == ALG_FIRST_INV) begin
              outer_pos <= '0;
              scan_pos  <= '0;
            end
            state <= S_RESULT;
          end else begin
            j     <= j + 1'b1;
            state <= S_CHK_RD;
          end
        end
        S_CK: begin
          if (!ck_back) begin
            if (j >= LAST_A) begin
              pass_cnt <= pc_inc;
              j        <= pass_j;
              ck_dir   <= 1'b1;
              ck_back  <= 1'b1;
            end else begin
              state <= S_SCAN_RD;
            end
          end else begin
            j     <= (j > PEN_A) ? PEN_A : j;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (stat.inv) begin
            sx       <= j;
            sy       <= j + 1'b1;
            scan_pos <= j;
            if (alg == ALG_COCKTAIL) begin
              back_dir <= ck_dir;
            end
            state <= S_SWAP_X;
          end else if (alg == ALG_BUBBLE) begin
            j     <= (j == PEN_A) ? '0 : j + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            state <= S_CK;
            if (!ck_back) begin
              if (j == PEN_A) begin
                pass_cnt <= pc_inc;
                j        <= pass_j;
                ck_dir   <= 1'b1;
                ck_back  <= 1'b1;
              end else begin
                j <= j + 1'b1;
              end
            end else if (j == '0) begin
              ck_dir  <= 1'b0;
              ck_back <= 1'b0;
            end else begin
              j <= j - 1'b1;
              if (j == AW'(1)) begin
                ck_dir <= 1'b0;
              end
            end
          end
        end
        S_SEL_RD: begin
          state <= S_SEL_EV;
        end
        S_SEL_EV: begin
          m <= p + 1'b1;
          k <= (AW + 1)'(p) + (AW + 1)'(2);
          if (((AW + 1)'(p) + (AW + 1)'(2)) < ENT_K) begin
            state <= S_SEL_KRD;
          end else begin
            state <= S_SEL_DEC;
          end
        end
        S_SEL_KRD: begin
          state <= S_SEL_KEV;
        end
        S_SEL_KEV: begin
          if (stat.min_gt) begin
            m <= k[AW-1:0];
          end
          k     <= k_inc;
          state <= (k_inc < ENT_K) ? S_SEL_KRD : S_SEL_DEC;
        end
        S_SEL_DEC: begin
          if (stat.sel_swap) begin
            sx        <= p;
            sy        <= m;
            outer_pos <= p;
            state     <= S_SWAP_X;
          end else begin
            p     <= (p == PEN_A) ? '0 : p + 1'b1;
            state <= S_SEL_RD;
          end
        end
        S_SWAP_X: begin
          state <= S_SWAP_Y;
        end
        S_SWAP_Y: begin
          rs_swap <= 1'b1;
          rs_lo   <= sx_wide[7:0];
          rs_hi   <= sy_wide[7:0];
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/stepwise_swap_sorter.sv
// ----------------------------------------------------------------------------
// stepwise_swap_sorter
// in-place array sorter making at most one exchange per step word
// ----------------------------------------------------------------------------
// load and read words go via S_LOAD or S_RD to S_RESULT; unknown words go straight there
// a step word: sorted check (S_CHK_RD, S_CHK_EV) over up to ENTRIES-1 pairs, then the scan
//   (cocktail adds S_CK, first-inversion has none), then the swap writes and the result state
// selection reads each remaining entry (S_SEL_KRD, S_SEL_KEV) at each outer position it visits
// one word at a time; the next word is taken the cycle after the result is registered
// synchronous reset clears positions and algorithm; memory contents undefined
module stepwise_swap_sorter import ssw_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  index,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        swapped,
  output logic        done_res,
  output logic [7:0]  first_index,
  output logic [7:0]  second_index,
  output logic [15:0] read_value
);

  localparam int AW = $clog2(ENTRIES);

  // command and status between sequencer and datapath
  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [AW-1:0] waddr;

  // sequencer: positions, scan counters, handshakes
  ssw_controller #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .index     (index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .ra        (ra),
    .rb        (rb),
    .waddr     (waddr)
  );

  // value memory with two registered read ports and result registers
  ssw_datapath #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .ra           (ra),
    .rb           (rb),
    .waddr        (waddr),
    .value        (value),
    .stat         (stat),
    .swapped      (swapped),
    .done_res     (done_res),
    .first_index  (first_index),
    .second_index (second_index),
    .read_value   (read_value)
  );

endmodule
